FILE: rtl/pt_pkg.sv
package pt_pkg;

  // Default width of the tested number.
  localparam int DATA_WIDTH_DEFAULT = 32;

  // Number of entries in the queue between the classifier and the divider.
  localparam int QUEUE_DEPTH = 2;

  // The first odd trial divisor and its square.
  localparam int FIRST_DIVISOR = 3;
  localparam int FIRST_SQUARE  = FIRST_DIVISOR * FIRST_DIVISOR;

  // Step that takes the square of an odd divisor d to the square of d + 2 is 4d + 4.
  localparam int DIVISOR_STEP = 2;
  localparam int SQUARE_STEP  = 4;

  // Verdict of the front classifier for one beat.
  typedef struct packed {
    logic decided;  // answer already known, no trial division needed
    logic flag;     // the answer when decided is set
  } pt_class_t;

endpackage

FILE: rtl/pt_front.sv
module pt_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] number,
  input  logic                  full,
  output logic                  push,
  output logic [DATA_WIDTH-1:0] push_value,
  output pt_pkg::pt_class_t     push_class
);
  import pt_pkg::*;

  logic negative;
  logic below_two;
  logic is_two;
  logic is_even;

  // Negative values, 0, 1 and every even value are settled here without division.
  assign negative  = number[DATA_WIDTH-1];
  assign below_two = (number[DATA_WIDTH-1:1] == '0);
  assign is_two    = (number == DATA_WIDTH'(2));
  assign is_even   = ~number[0];

  assign push_class.decided = negative | below_two | is_even;
  assign push_class.flag    = is_two;

  assign push       = in_valid & ~full;
  assign in_stall   = full;
  assign push_value = number;

endmodule

FILE: rtl/pt_queue.sv
module pt_queue #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  import pt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push && !full, pop && not_empty})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/pt_back.sv
module pt_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [DATA_WIDTH-1:0] q_value,
  input  pt_pkg::pt_class_t     q_class,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_prime_flag
);
  import pt_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(DATA_WIDTH);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]    state;
  logic [W-1:0]  value;
  logic [W-1:0]  divisor;
  logic [W:0]    square;
  logic [W-1:0]  rem;
  logic [CW-1:0] bit_idx;
  logic          verdict;

  logic [W:0]    trial;
  logic [W:0]    trial_sub;
  logic          trial_ge;
  logic [W-1:0]  rem_next;
  logic [W:0]    square_next;
  logic          out_free;

  // One restoring division step: bring in the next dividend bit and subtract if it fits.
  assign trial     = {rem, value[bit_idx]};
  assign trial_ge  = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_next  = trial_ge ? trial_sub[W-1:0] : trial[W-1:0];

  // (d + 2)^2 = d^2 + 4d + 4, so the square follows the divisor with one add.
  assign square_next = square + {divisor[W-2:0], 2'b00} + (W+1)'(SQUARE_STEP);

  assign out_free = ~out_valid | ~out_stall;
  assign pop      = (state == ST_IDLE) & q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A beat leaving the output register is replaced right away in ST_DONE.
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= q_class.decided ? ST_DONE : ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= (square > {1'b0, value}) ? ST_DONE : ST_DIV;
        end
        ST_DIV: begin
          if (bit_idx == '0) begin
            state <= (rem_next == '0) ? ST_DONE : ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        value   <= q_value;
        verdict <= q_class.flag;
        divisor <= W'(FIRST_DIVISOR);
        square  <= (W+1)'(FIRST_SQUARE);
      end
      ST_CHECK: begin
        verdict <= 1'b1;
        rem     <= '0;
        bit_idx <= CW'(W - 1);
      end
      ST_DIV: begin
        rem     <= rem_next;
        bit_idx <= bit_idx - CW'(1);
        if (bit_idx == '0) begin
          verdict <= 1'b0;
          divisor <= divisor + W'(DIVISOR_STEP);
          square  <= square_next;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          is_prime_flag <= verdict;
        end
      end
      default: begin
        verdict <= 1'b0;
      end
    endcase
  end

endmodule

FILE: rtl/prime_test_unit.sv
// Trial-division primality test. Each input beat carries one signed number of
// DATA_WIDTH bits, and each output beat returns is_prime_flag, which is 1
// exactly when that number is prime; results leave in the order the numbers
// arrived. A front classifier settles negative values, 0, 1, 2 and every even
// value at once and writes each beat into a two-entry queue, so the input keeps
// flowing while the back end works, until the queue is full. The back end tries
// odd divisors from 3 upward while the divisor squared does not exceed the
// number, using one serial restoring divider that produces one quotient bit per
// cycle. A number settled by the classifier passes through the queue and the
// IDLE and DONE states into the output register without division. Each trial
// divisor for an odd number costs one bound check plus DATA_WIDTH divide steps.
// Numbers are processed one at a time in the back end; up to two more wait in
// the queue and one finished result waits in the output register.
module prime_test_unit #(
  parameter int DATA_WIDTH = pt_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] number,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_prime_flag
);
  import pt_pkg::*;

  // Queue entries hold the number together with the classifier's verdict.
  localparam int QW = DATA_WIDTH + $bits(pt_class_t);

  logic                  push;
  logic                  full;
  logic [DATA_WIDTH-1:0] push_value;
  pt_class_t             push_class;
  logic                  pop;
  logic                  q_valid;
  logic [QW-1:0]         q_data;
  logic [DATA_WIDTH-1:0] q_value;
  pt_class_t             q_class;

  pt_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .number    (number),
    .full      (full),
    .push      (push),
    .push_value(push_value),
    .push_class(push_class)
  );

  pt_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_value, push_class}),
    .full     (full),
    .pop      (pop),
    .not_empty(q_valid),
    .pop_data (q_data)
  );

  // Split the queue word back into the number and its verdict.
  assign q_value = q_data[QW-1 -: DATA_WIDTH];
  assign q_class = q_data[$bits(pt_class_t)-1:0];

  pt_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_value      (q_value),
    .q_class      (q_class),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_prime_flag(is_prime_flag)
  );

endmodule

FILE: rtl/pt_checker.sv
module pt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic is_prime_flag
);
  import pt_pkg::*;

  // Two queue entries, one number in the divider and one result in the output register.
  localparam int MAX_PENDING = QUEUE_DEPTH + 2;
  localparam int PCW         = $clog2(MAX_PENDING + 2);

  logic [PCW-1:0] pending;
  logic           in_beat;
  logic           out_beat;

  assign in_beat  = in_valid & ~in_stall;
  assign out_beat = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({in_beat, out_beat})
        2'b10:   pending <= pending + PCW'(1);
        2'b01:   pending <= pending - PCW'(1);
        default: pending <= pending;
      endcase
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != '0)
    else $error("result beat offered with no number outstanding");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending <= PCW'(MAX_PENDING))
    else $error("more numbers outstanding than the block can hold");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result beat dropped");

  a_flag_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(is_prime_flag))
    else $error("stalled result beat changed");

endmodule

bind prime_test_unit pt_checker u_pt_checker (.*);
